// File: rtl/tca_pkg.sv
// ============================================================================
// tca_pkg
// Shared types and constants of the text console append engine.
// ============================================================================
package tca_pkg;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam logic [15:0] BLANK_CELL   = 16'h0F20;
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [7:0]  CHAR_TAB     = 8'h09;
    localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
    localparam logic [3:0]  TAB_RESET    = 4'd4;
    localparam logic [3:0]  TAB_MAX      = 4'd8;

    localparam int CELL_W = 16;

endpackage

// File: rtl/tca_ram.sv
// ============================================================================
// tca_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module tca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/text_console_append_top.sv
// ============================================================================
// text_console_append_top
// Text console engine: cell buffer in RAM, linear cursor, scroll and clear.
// ============================================================================
// Input channel (i_valid / o_ready) carries one request: append a character
// (tab and newline expand to several cells), clear the screen, or read one
// cell. Every request returns exactly one result on the output channel
// (o_valid / i_ready): cursor after the request, the read cell, scroll flag.
// One request is in flight at a time; the next is taken once the current
// one has moved to the output register, even while that result is stalled.
// A tab writes 1 to 8 spaces and a newline fills the rest of its row.
// A scroll copies the buffer up one row, a cell per cycle through the RAM
// (read one row ahead, write in the next cycle), and blanks the last row.
// After reset the RAM is blanked by a sweep over every cell; o_ready
// stays low meanwhile. tab_width resets to 4 and may be written any time
// the block is idle. A stalled output holds its result; the block finishes
// the next request and then waits for the output register to free up.
// ============================================================================
module text_console_append_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_color,
    input  logic [10:0] i_cell_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_cursor_loc,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_color,
    output logic        o_scrolled
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int COPY_LEN = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CUR_W    = $clog2(CELLS + 1);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int CNT_MAX  = (COLUMNS > 8) ? COLUMNS : 8;
    localparam int CNT_W    = $clog2(CNT_MAX + 1);

    localparam logic [CUR_W-1:0]  CUR_FULL  = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0]  CUR_LAST  = CUR_W'(COPY_LEN);
    localparam logic [ADDR_W-1:0] PTR_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] PTR_COPY  = ADDR_W'(COPY_LEN);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_PUT    = 8'b0000_0100,
        S_SCROLL = 8'b0000_1000,
        S_SDRAIN = 8'b0001_0000,
        S_RD     = 8'b0010_0000,
        S_RDW    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state                       r_state;
    logic [ADDR_W-1:0]            r_ptr;
    logic                         r_clr_item;
    logic [CUR_W-1:0]             r_cursor;
    logic [COL_W-1:0]             r_col;
    logic [CNT_W-1:0]             r_cnt;
    logic [tca_pkg::CELL_W-1:0]   r_put_val;
    logic [10:0]                  r_idx;
    logic [tca_pkg::CELL_W-1:0]   r_rd;
    logic                         r_scr;
    logic [3:0]                   r_tab;
    logic                         r_wv;
    logic [ADDR_W-1:0]            r_wa;
    logic                         r_wcopy;
    logic                         r_ov;
    logic [10:0]                  r_out_cursor;
    logic [tca_pkg::CELL_W-1:0]   r_out_cell;
    logic                         r_out_scr;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [tca_pkg::CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [tca_pkg::CELL_W-1:0]   ram_rdata;

    logic                         full;
    logic                         idx_ok;
    logic                         out_free;
    logic [CNT_W-1:0]             tab_cnt;
    logic [CNT_W-1:0]             nl_cnt;

    assign full     = (r_cursor >= CUR_FULL);
    assign idx_ok   = (32'(i_cell_index) < 32'(CELLS));
    assign out_free = !r_ov || i_ready;
    assign nl_cnt   = CNT_W'(COLUMNS) - CNT_W'(r_col);

    always_comb begin
        if (r_tab == 4'd0) begin
            tab_cnt = CNT_W'(1);
        end else if (r_tab > tca_pkg::TAB_MAX) begin
            tab_cnt = CNT_W'(tca_pkg::TAB_MAX);
        end else begin
            tab_cnt = CNT_W'(r_tab);
        end
    end

    // RAM port selection; the delayed scroll write is the only one in flight
    // in the scroll states, so the arms never collide.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = tca_pkg::BLANK_CELL;
        if (r_ptr < PTR_COPY) begin
            ram_raddr = ADDR_W'(32'(r_ptr) + COLUMNS);
        end else begin
            ram_raddr = r_ptr;
        end
        if (r_state == S_RD) begin
            ram_raddr = ADDR_W'(r_idx);
        end
        if (r_wv) begin
            ram_we    = 1'b1;
            ram_waddr = r_wa;
            ram_wdata = r_wcopy ? ram_rdata : tca_pkg::BLANK_CELL;
        end else if (r_state == S_INIT) begin
            ram_we    = 1'b1;
        end else if (r_state == S_PUT && !full) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(r_cursor);
            ram_wdata = r_put_val;
        end
    end

    tca_ram #(
        .WIDTH (tca_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_tca_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_ptr      <= '0;
            r_clr_item <= 1'b0;
            r_cursor   <= '0;
            r_col      <= '0;
            r_tab      <= tca_pkg::TAB_RESET;
            r_wv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tab <= i_cfg_data;
            end
            r_wv <= 1'b0;
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == PTR_LAST) begin
                        r_ptr   <= '0;
                        r_state <= r_clr_item ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_scr <= 1'b0;
                        r_rd  <= '0;
                        r_idx <= i_cell_index;
                        unique case (tca_pkg::t_kind'(i_kind))
                            tca_pkg::KIND_APPEND: begin
                                r_state <= S_PUT;
                                if (i_char_code == tca_pkg::CHAR_TAB) begin
                                    r_cnt     <= tab_cnt;
                                    r_put_val <= {i_color, tca_pkg::CHAR_SPACE};
                                end else if (i_char_code == tca_pkg::CHAR_NEWLINE) begin
                                    r_cnt     <= nl_cnt;
                                    r_put_val <= {8'h00, tca_pkg::CHAR_SPACE};
                                end else begin
                                    r_cnt     <= CNT_W'(1);
                                    r_put_val <= {i_color, i_char_code};
                                end
                            end
                            tca_pkg::KIND_CLEAR: begin
                                r_clr_item <= 1'b1;
                                r_ptr      <= '0;
                                r_cursor   <= '0;
                                r_col      <= '0;
                                r_state    <= S_INIT;
                            end
                            tca_pkg::KIND_READ: begin
                                r_state <= idx_ok ? S_RD : S_DONE;
                            end
                            tca_pkg::KIND_NONE: begin
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_PUT: begin
                    if (full) begin
                        r_ptr   <= '0;
                        r_state <= S_SCROLL;
                    end else begin
                        r_cursor <= r_cursor + 1'b1;
                        r_col    <= (r_col == COL_LAST) ? '0 : r_col + 1'b1;
                        r_cnt    <= r_cnt - 1'b1;
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCROLL: begin
                    // read issued this cycle, write lands in the next cycle
                    r_wv    <= 1'b1;
                    r_wa    <= r_ptr;
                    r_wcopy <= (r_ptr < PTR_COPY);
                    r_ptr   <= r_ptr + 1'b1;
                    if (r_ptr == PTR_LAST) begin
                        r_ptr   <= '0;
                        r_state <= S_SDRAIN;
                    end
                end
                S_SDRAIN: begin
                    r_cursor <= CUR_LAST;
                    r_col    <= '0;
                    r_scr    <= 1'b1;
                    r_state  <= S_PUT;
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_rd    <= ram_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ov         <= 1'b1;
                        r_out_cursor <= 11'(r_cursor);
                        r_out_cell   <= r_rd;
                        r_out_scr    <= r_scr;
                        r_clr_item   <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ov;
    assign o_cursor_loc = r_out_cursor;
    assign o_cell_char  = r_out_cell[7:0];
    assign o_cell_color = r_out_cell[15:8];
    assign o_scrolled   = r_out_scr;

endmodule

// File: rtl/tca_checker.sv
// ============================================================================
// tca_checker
// Port-level checks of the text console append engine, bound to the top.
// ============================================================================
module tca_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [10:0] o_cursor_loc,
    input logic [7:0]  o_cell_char,
    input logic [7:0]  o_cell_color,
    input logic        o_scrolled
);

    localparam int  CELLS   = COLUMNS * ROWS;
    localparam bit  FITS    = (CELLS < 2048);
    localparam logic [10:0] CUR_MAX  = 11'(CELLS);
    localparam logic [10:0] LAST_ROW = 11'((ROWS - 1) * COLUMNS);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cursor_loc) && $stable(o_scrolled))
        else $error("result changed while stalled");

    // the reset blanking sweep keeps requests out
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("ready or valid right after reset");

    // a read never scrolls
    a_read_no_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_cell_char != 8'd0 || o_cell_color != 8'd0) |-> !o_scrolled)
        else $error("read result with scroll flag");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FITS && o_valid |-> o_cursor_loc <= CUR_MAX)
        else $error("cursor beyond screen");

    // after a scroll the cursor sits on the last row or at the end
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FITS && o_valid && o_scrolled |-> o_cursor_loc >= LAST_ROW)
        else $error("scrolled but cursor above last row");

endmodule

bind text_console_append_top tca_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tca_checker (.*);

// File: dv/text_console_append_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// text_console_append_top_tb
// Self-checking bench for the text console engine. A short directed table
// covers the field extremes, every request kind, tab width clamping and
// scrolling from a full screen. Random requests follow, with both sides
// stalling in bursts outside the last phase. Typed rows are checked against
// table values, the rest against a cycle-free in-bench model of cells and cursor.
// ============================================================================
module text_console_append_top_tb;

    localparam int COLS  = 80;
    localparam int NROWS = 24;
    localparam int CELLS = COLS * NROWS;
    localparam int PHASE_REQUESTS = 195;

    typedef struct packed {
        tca_pkg::t_kind kind;
        logic [7:0]     char_code;
        logic [7:0]     color;
        logic [10:0]    cell_index;
    } t_console_req;

    typedef struct packed {
        logic [10:0] cursor_loc;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
        logic        scrolled;
    } t_console_result;

    typedef enum bit {ROW_REQUEST, ROW_TAB_WIDTH} t_row_op;

    typedef struct packed {
        t_row_op         op;
        logic [3:0]      tab_width;
        t_console_req    req;
        logic [7:0]      reps;
        bit              typed;
        t_console_result want;
    } t_dir_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [3:0]  i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_kind       = '0;
    logic [7:0]  i_char_code  = '0;
    logic [7:0]  i_color      = '0;
    logic [10:0] i_cell_index = '0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [10:0] o_cursor_loc;
    logic [7:0]  o_cell_char;
    logic [7:0]  o_cell_color;
    logic        o_scrolled;

    // console model state
    logic [tca_pkg::CELL_W-1:0] screen_m [CELLS];
    int                         cursor_m;
    logic [3:0]                 tab_width_m;
    bit                         scrolled_m;

    t_console_result results_due [$];
    t_console_result oldest_due;
    t_dir_row        dir_tab [$];
    int              mismatch_count = 0;
    int              rx_hold = 0;
    bit              no_idle = 1'b0;

    text_console_append_top #(
        .COLUMNS (COLS),
        .ROWS    (NROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_color      (i_color),
        .i_cell_index (i_cell_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cursor_loc (o_cursor_loc),
        .o_cell_char  (o_cell_char),
        .o_cell_color (o_cell_color),
        .o_scrolled   (o_scrolled)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Console model
    // ------------------------------------------------------------------
    task automatic write_console_cell(input logic [7:0] ch, input logic [7:0] attr);
        if (cursor_m >= CELLS) begin
            for (int i = 0; i < CELLS - COLS; i++)
                screen_m[i] = screen_m[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen_m[i] = tca_pkg::BLANK_CELL;
            cursor_m   = CELLS - COLS;
            scrolled_m = 1'b1;
        end
        screen_m[cursor_m] = {attr, ch};
        cursor_m++;
    endtask

    task automatic console_model_step(input t_console_req rq, output t_console_result res);
        int n;
        res        = '0;
        scrolled_m = 1'b0;
        case (rq.kind)
            tca_pkg::KIND_APPEND: begin
                if (rq.char_code == tca_pkg::CHAR_TAB) begin
                    n = tab_width_m;
                    if (n < 1) n = 1;
                    if (n > tca_pkg::TAB_MAX) n = tca_pkg::TAB_MAX;
                    repeat (n) write_console_cell(tca_pkg::CHAR_SPACE, rq.color);
                end else if (rq.char_code == tca_pkg::CHAR_NEWLINE) begin
                    // line length is fixed before any scroll
                    n = COLS - (cursor_m % COLS);
                    repeat (n) write_console_cell(tca_pkg::CHAR_SPACE, 8'h00);
                end else begin
                    write_console_cell(rq.char_code, rq.color);
                end
            end
            tca_pkg::KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_m[i] = tca_pkg::BLANK_CELL;
                cursor_m = 0;
            end
            tca_pkg::KIND_READ: begin
                if (rq.cell_index < CELLS) begin
                    res.cell_char  = screen_m[rq.cell_index][7:0];
                    res.cell_color = screen_m[rq.cell_index][15:8];
                end
            end
            default: ;
        endcase
        res.cursor_loc = cursor_m[10:0];
        res.scrolled   = scrolled_m;
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++)
            screen_m[i] = tca_pkg::BLANK_CELL;
        cursor_m    = 0;
        tab_width_m = tca_pkg::TAB_RESET;
    end

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic t_dir_row req_row(input tca_pkg::t_kind k, input logic [7:0] ch,
                                         input logic [7:0] col, input logic [10:0] idx,
                                         input logic [7:0] reps);
        t_dir_row r;
        r      = '0;
        r.op   = ROW_REQUEST;
        r.req  = '{k, ch, col, idx};
        r.reps = reps;
        return r;
    endfunction

    function automatic t_dir_row typed_row(input tca_pkg::t_kind k, input logic [7:0] ch,
                                           input logic [7:0] col, input logic [10:0] idx,
                                           input logic [10:0] cur, input logic [7:0] rch,
                                           input logic [7:0] rcol);
        t_dir_row r;
        r       = req_row(k, ch, col, idx, 8'd1);
        r.typed = 1'b1;
        r.want  = '{cur, rch, rcol, 1'b0};
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [3:0] v);
        t_dir_row r;
        r           = '0;
        r.op        = ROW_TAB_WIDTH;
        r.tab_width = v;
        return r;
    endfunction

    function automatic t_console_req random_request();
        t_console_req rq;
        int           pick;
        int           back;
        rq.kind       = tca_pkg::KIND_APPEND;
        rq.char_code  = 8'($urandom_range(0, 255));
        rq.color      = 8'($urandom_range(0, 255));
        rq.cell_index = 11'($urandom_range(0, 2047));
        pick          = $urandom_range(0, 99);
        if (pick < 55) begin
            rq.kind = tca_pkg::KIND_APPEND;
        end else if (pick < 65) begin
            rq.char_code = tca_pkg::CHAR_TAB;
        end else if (pick < 76) begin
            rq.char_code = tca_pkg::CHAR_NEWLINE;
        end else if (pick < 96) begin
            rq.kind = tca_pkg::KIND_READ;
            // mostly look at cells just written
            back = $urandom_range(1, 120);
            if ($urandom_range(0, 3) != 0)
                rq.cell_index = (cursor_m >= back && cursor_m - back < CELLS) ?
                                11'(cursor_m - back) : 11'($urandom_range(0, CELLS - 1));
        end else if (pick < 97) begin
            rq.kind = tca_pkg::KIND_CLEAR;
        end else begin
            rq.kind = tca_pkg::KIND_NONE;
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(input t_console_req rq, input bit use_typed,
                                input t_console_result typed_want);
        t_console_result want;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= rq.kind;
        i_char_code  <= rq.char_code;
        i_color      <= rq.color;
        i_cell_index <= rq.cell_index;
        do @(posedge i_clk); while (!o_ready);
        console_model_step(rq, want);
        results_due.push_back(use_typed ? typed_want : want);
    endtask

    task automatic wait_drained(input int quiet);
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (quiet) @(posedge i_clk);
    endtask

    task automatic write_tab_width(input logic [3:0] v);
        wait_drained(8);
        while (!o_ready) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tab_width_m = v;
    endtask

    initial begin
        t_console_req rq;
        logic [3:0]   tw;
        int           done;

        dir_tab.push_back(typed_row(tca_pkg::KIND_READ, 8'h00, 8'h00, 11'd0, 11'd0,
                                    tca_pkg::BLANK_CELL[7:0], tca_pkg::BLANK_CELL[15:8]));
        dir_tab.push_back(typed_row(tca_pkg::KIND_READ, 8'h00, 8'h00, 11'h7FF, 11'd0,
                                    8'h00, 8'h00));
        dir_tab.push_back(typed_row(tca_pkg::KIND_NONE, 8'hFF, 8'hFF, 11'h7FF, 11'd0,
                                    8'h00, 8'h00));
        dir_tab.push_back(typed_row(tca_pkg::KIND_APPEND, 8'h00, 8'h00, 11'd0, 11'd1,
                                    8'h00, 8'h00));
        dir_tab.push_back(typed_row(tca_pkg::KIND_APPEND, 8'hFF, 8'hFF, 11'd0, 11'd2,
                                    8'h00, 8'h00));
        dir_tab.push_back(typed_row(tca_pkg::KIND_READ, 8'h00, 8'h00, 11'd1, 11'd2,
                                    8'hFF, 8'hFF));
        dir_tab.push_back(req_row(tca_pkg::KIND_APPEND, tca_pkg::CHAR_TAB, 8'hA5, 11'd0, 8'd1));
        dir_tab.push_back(req_row(tca_pkg::KIND_APPEND, tca_pkg::CHAR_NEWLINE, 8'h77, 11'd0,
                                  8'd1));
        // tab width zero still writes one space
        dir_tab.push_back(cfg_row(4'd0));
        dir_tab.push_back(req_row(tca_pkg::KIND_APPEND, tca_pkg::CHAR_TAB, 8'h5A, 11'd0, 8'd1));
        // tab width above the maximum is clamped
        dir_tab.push_back(cfg_row(4'd15));
        dir_tab.push_back(req_row(tca_pkg::KIND_APPEND, tca_pkg::CHAR_TAB, 8'h3C, 11'd0, 8'd1));
        dir_tab.push_back(cfg_row(tca_pkg::TAB_MAX));
        dir_tab.push_back(req_row(tca_pkg::KIND_APPEND, tca_pkg::CHAR_TAB, 8'hC3, 11'd0, 8'd1));
        dir_tab.push_back(req_row(tca_pkg::KIND_READ, 8'h00, 8'h00, 11'd81, 8'd1));
        dir_tab.push_back(req_row(tca_pkg::KIND_READ, 8'h00, 8'h00, 11'(CELLS - 1), 8'd1));
        dir_tab.push_back(cfg_row(4'd1));
        dir_tab.push_back(typed_row(tca_pkg::KIND_CLEAR, 8'h41, 8'h1E, 11'd5, 11'd0,
                                    8'h00, 8'h00));
        // fill the screen, then newline and a character with the cursor past the end
        dir_tab.push_back(req_row(tca_pkg::KIND_APPEND, tca_pkg::CHAR_NEWLINE, 8'h00, 11'd0,
                                  8'(NROWS)));
        dir_tab.push_back(req_row(tca_pkg::KIND_APPEND, tca_pkg::CHAR_NEWLINE, 8'hE1, 11'd0,
                                  8'd1));
        dir_tab.push_back(req_row(tca_pkg::KIND_APPEND, 8'h41, 8'h1E, 11'd0, 8'd1));
        dir_tab.push_back(req_row(tca_pkg::KIND_READ, 8'h00, 8'h00, 11'(CELLS - COLS), 8'd1));
        dir_tab.push_back(req_row(tca_pkg::KIND_READ, 8'h00, 8'h00, 11'(CELLS - 1), 8'd1));
        dir_tab.push_back(cfg_row(tca_pkg::TAB_RESET));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].op == ROW_TAB_WIDTH)
                write_tab_width(dir_tab[r].tab_width);
            else
                repeat (dir_tab[r].reps)
                    send_request(dir_tab[r].req, dir_tab[r].typed, dir_tab[r].want);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       tw = 4'd1;
                1:       tw = tca_pkg::TAB_MAX;
                2:       tw = 4'd0;
                3:       tw = 4'd15;
                default: tw = 4'($urandom_range(0, 15));
            endcase
            write_tab_width(tw);
            no_idle = (ph == 5);
            done    = 0;
            while (done < PHASE_REQUESTS) begin
                rq = random_request();
                send_request(rq, 1'b0, '0);
                if (rq.kind != tca_pkg::KIND_NONE) done++;
            end
        end

        wait_drained(CELLS + 8);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            rx_hold = 0;
            i_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(0, 14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (results_due.size() == 0) begin
                $error("result with no request pending: cursor_loc %0d", o_cursor_loc);
                mismatch_count++;
            end else begin
                oldest_due = results_due.pop_front();
                if (o_cursor_loc !== oldest_due.cursor_loc) begin
                    $error("cursor_loc: expected %0d, got %0d",
                           oldest_due.cursor_loc, o_cursor_loc);
                    mismatch_count++;
                end
                if (o_cell_char !== oldest_due.cell_char) begin
                    $error("cell_char: expected 0x%02h, got 0x%02h",
                           oldest_due.cell_char, o_cell_char);
                    mismatch_count++;
                end
                if (o_cell_color !== oldest_due.cell_color) begin
                    $error("cell_color: expected 0x%02h, got 0x%02h",
                           oldest_due.cell_color, o_cell_color);
                    mismatch_count++;
                end
                if (o_scrolled !== oldest_due.scrolled) begin
                    $error("scrolled: expected %0b, got %0b", oldest_due.scrolled, o_scrolled);
                    mismatch_count++;
                end
            end
        end
    end

endmodule

// File: text_console_append_top.f
rtl/tca_pkg.sv
rtl/tca_ram.sv
rtl/text_console_append_top.sv
rtl/tca_checker.sv
dv/text_console_append_top_tb.sv
